// ===== src/bib_pkg.sv =====
// shared types and constants for the body integrate and wall bounce pipeline
package bib_pkg;

  // stream widths
  localparam int IN_TDATA_W  = 232;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 128;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd5;

  // configuration registers
  typedef struct packed {
    logic        [16:0] time_step;
    logic signed [31:0] gravity_x;
    logic signed [31:0] gravity_y;
    logic        [30:0] world_width;
    logic        [30:0] world_height;
    logic        [30:0] speed_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    time_step:    17'd1092,
    gravity_x:    32'sd0,
    gravity_y:    32'sd32768000,
    world_width:  31'd83886080,
    world_height: 31'd47185920,
    speed_limit:  31'd131072000
  };

  // one input body
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               is_circle;
    logic        [30:0] extent_x;
    logic        [30:0] extent_y;
    logic        [16:0] restitution;
    logic        [18:0] friction_coef;
    logic               is_static;
    logic               alive;
  } body_t;

  // integrated body handed to the wall stages
  typedef struct packed {
    body_t              body;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic        [30:0] avx;
    logic        [30:0] avy;
    logic        [35:0] dv;
  } kin_t;

  // confined body handed to the friction stages
  typedef struct packed {
    body_t              body;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic        [30:0] ry;
    logic               floor_hit;
    logic        [35:0] dv;
  } wall_t;

  // one result body
  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               keep;
    logic               on_floor;
  } result_t;

endpackage

// ===== src/bib_cfg.sv =====
// configuration register file
module bib_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bib_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bib_pkg::CFG_DATA_W-1:0] cfg_data,
  output bib_pkg::cfg_t                  cfg
);
  import bib_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg        = cfg_r;

  // register write, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIME_STEP:    cfg_r.time_step    <= cfg_data[16:0];
        REG_GRAVITY_X:    cfg_r.gravity_x    <= cfg_data;
        REG_GRAVITY_Y:    cfg_r.gravity_y    <= cfg_data;
        REG_WORLD_WIDTH:  cfg_r.world_width  <= cfg_data[30:0];
        REG_WORLD_HEIGHT: cfg_r.world_height <= cfg_data[30:0];
        REG_SPEED_LIMIT:  cfg_r.speed_limit  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/bib_integ.sv =====
// velocity and position integration, five pipeline stages
module bib_integ (
  input  logic           clk,
  input  logic           rst_n,
  input  bib_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  bib_pkg::body_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bib_pkg::kin_t  out_data
);
  import bib_pkg::*;

  localparam logic signed [34:0] S32_MAX = 35'sd2147483647;
  localparam logic signed [34:0] S32_MIN = -35'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > S32_MAX) sat32 = S32_MAX[31:0];
    else if (v < S32_MIN) sat32 = S32_MIN[31:0];
    else sat32 = v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_lim(input logic signed [34:0] v,
                                                   input logic [30:0] lim);
    logic signed [34:0] lp;
    logic signed [34:0] ln;
    lp = $signed({4'b0, lim});
    ln = -lp;
    if (v > lp) clamp_lim = lp[31:0];
    else if (v < ln) clamp_lim = ln[31:0];
    else clamp_lim = v[31:0];
  endfunction

  function automatic logic [30:0] abs31(input logic signed [31:0] v);
    logic signed [31:0] n;
    n = -v;
    abs31 = v[31] ? n[30:0] : v[30:0];
  endfunction

  // stage handshake: a stage loads when empty or when the next one loads
  logic [4:0] v_r;
  logic [5:0] go;

  assign go[5] = out_ready;
  assign go[4] = ~v_r[4] | go[5];
  assign go[3] = ~v_r[3] | go[4];
  assign go[2] = ~v_r[2] | go[3];
  assign go[1] = ~v_r[1] | go[2];
  assign go[0] = ~v_r[0] | go[1];

  assign in_ready  = go[0];
  assign out_valid = v_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (go[0]) v_r[0] <= in_valid;
      if (go[1]) v_r[1] <= v_r[0];
      if (go[2]) v_r[2] <= v_r[1];
      if (go[3]) v_r[3] <= v_r[2];
      if (go[4]) v_r[4] <= v_r[3];
    end
  end

  logic signed [17:0] dt_s;
  assign dt_s = $signed({1'b0, cfg.time_step});

  // stage 1: gravity times step, friction deceleration product
  body_t              b1_r;
  logic signed [49:0] pgx1_r, pgy1_r;
  logic        [50:0] pdec1_r;
  logic signed [49:0] pgx_c, pgy_c;
  logic        [50:0] pdec_c;
  logic signed [31:0] gy_neg;
  logic        [31:0] gy_abs;

  assign gy_neg = -$signed(cfg.gravity_y);
  assign gy_abs = cfg.gravity_y[31] ? gy_neg : cfg.gravity_y;
  assign pgx_c  = $signed(cfg.gravity_x) * dt_s;
  assign pgy_c  = $signed(cfg.gravity_y) * dt_s;
  assign pdec_c = in_data.friction_coef * gy_abs;

  always_ff @(posedge clk) begin
    if (go[0]) begin
      b1_r    <= in_data;
      pgx1_r  <= pgx_c;
      pgy1_r  <= pgy_c;
      pdec1_r <= pdec_c;
    end
  end

  // stage 2: round the products
  body_t              b2_r;
  logic signed [33:0] gx2_r, gy2_r;
  logic        [34:0] dec2_r;
  logic signed [49:0] gsx_c, gsy_c;
  logic        [50:0] dsum_c;

  assign gsx_c  = pgx1_r + 50'sd32768;
  assign gsy_c  = pgy1_r + 50'sd32768;
  assign dsum_c = pdec1_r + 51'd32768;

  always_ff @(posedge clk) begin
    if (go[1]) begin
      b2_r   <= b1_r;
      gx2_r  <= $signed(gsx_c[49:16]);
      gy2_r  <= $signed(gsy_c[49:16]);
      dec2_r <= dsum_c[50:16];
    end
  end

  // stage 3: velocity update with speed clamp, friction step product
  body_t              b3_r;
  logic signed [31:0] vx3_r, vy3_r;
  logic        [51:0] pdv3_r;
  logic signed [34:0] vsx_c, vsy_c;

  assign vsx_c = 35'($signed(b2_r.vel_x)) + 35'(gx2_r);
  assign vsy_c = 35'($signed(b2_r.vel_y)) + 35'(gy2_r);

  always_ff @(posedge clk) begin
    if (go[2]) begin
      b3_r   <= b2_r;
      vx3_r  <= clamp_lim(vsx_c, cfg.speed_limit);
      vy3_r  <= clamp_lim(vsy_c, cfg.speed_limit);
      pdv3_r <= dec2_r * cfg.time_step;
    end
  end

  // stage 4: velocity times step
  body_t              b4_r;
  logic signed [31:0] vx4_r, vy4_r;
  logic signed [49:0] pmx4_r, pmy4_r;
  logic        [51:0] pdv4_r;
  logic signed [49:0] pmx_c, pmy_c;

  assign pmx_c = vx3_r * dt_s;
  assign pmy_c = vy3_r * dt_s;

  always_ff @(posedge clk) begin
    if (go[3]) begin
      b4_r   <= b3_r;
      vx4_r  <= vx3_r;
      vy4_r  <= vy3_r;
      pmx4_r <= pmx_c;
      pmy4_r <= pmy_c;
      pdv4_r <= pdv3_r;
    end
  end

  // stage 5: position update, friction step rounding, speed magnitudes
  kin_t               k5_r;
  logic signed [49:0] msx_c, msy_c;
  logic signed [34:0] psx_c, psy_c;
  logic        [51:0] dvs_c;

  assign msx_c = pmx4_r + 50'sd32768;
  assign msy_c = pmy4_r + 50'sd32768;
  assign psx_c = 35'($signed(b4_r.pos_x)) + 35'($signed(msx_c[49:16]));
  assign psy_c = 35'($signed(b4_r.pos_y)) + 35'($signed(msy_c[49:16]));
  assign dvs_c = pdv4_r + 52'd32768;

  always_ff @(posedge clk) begin
    if (go[4]) begin
      k5_r.body <= b4_r;
      k5_r.px   <= sat32(psx_c);
      k5_r.py   <= sat32(psy_c);
      k5_r.vx   <= vx4_r;
      k5_r.vy   <= vy4_r;
      k5_r.avx  <= abs31(vx4_r);
      k5_r.avy  <= abs31(vy4_r);
      k5_r.dv   <= dvs_c[51:16];
    end
  end

  assign out_data = k5_r;

endmodule

// ===== src/bib_walls.sv =====
// wall confinement and restitution, five pipeline stages
module bib_walls (
  input  logic           clk,
  input  logic           rst_n,
  input  bib_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  bib_pkg::kin_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bib_pkg::wall_t out_data
);
  import bib_pkg::*;

  // saturate the negated magnitude to the 32-bit range
  function automatic logic signed [31:0] sat_neg(input logic [31:0] r);
    if (r > 32'h8000_0000) sat_neg = 32'sh8000_0000;
    else sat_neg = 32'(-r);
  endfunction

  // stage handshake
  logic [4:0] v_r;
  logic [5:0] go;

  assign go[5] = out_ready;
  assign go[4] = ~v_r[4] | go[5];
  assign go[3] = ~v_r[3] | go[4];
  assign go[2] = ~v_r[2] | go[3];
  assign go[1] = ~v_r[1] | go[2];
  assign go[0] = ~v_r[0] | go[1];

  assign in_ready  = go[0];
  assign out_valid = v_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (go[0]) v_r[0] <= in_valid;
      if (go[1]) v_r[1] <= v_r[0];
      if (go[2]) v_r[2] <= v_r[1];
      if (go[3]) v_r[3] <= v_r[2];
      if (go[4]) v_r[4] <= v_r[3];
    end
  end

  // stage 1: wall hits in order left, right, top, floor and new positions
  logic        [30:0] ry_c;
  logic signed [33:0] px_e, py_e, rx_e, ry_e, w_e, h_e;
  logic signed [33:0] pcx_c, pcy_c, wr_c, hr_c;
  logic               lft_c, rgt_c, top_c, flr_c;

  assign ry_c  = in_data.body.is_circle ? in_data.body.extent_x : in_data.body.extent_y;
  assign px_e  = 34'($signed(in_data.px));
  assign py_e  = 34'($signed(in_data.py));
  assign rx_e  = $signed({3'b0, in_data.body.extent_x});
  assign ry_e  = $signed({3'b0, ry_c});
  assign w_e   = $signed({3'b0, cfg.world_width});
  assign h_e   = $signed({3'b0, cfg.world_height});
  assign lft_c = px_e < rx_e;
  assign pcx_c = lft_c ? rx_e : px_e;
  assign rgt_c = (pcx_c + rx_e) > w_e;
  assign top_c = py_e < ry_e;
  assign pcy_c = top_c ? ry_e : py_e;
  assign flr_c = (pcy_c + ry_e) > h_e;
  assign wr_c  = w_e - rx_e;
  assign hr_c  = h_e - ry_e;

  kin_t               k1_r;
  logic        [30:0] ry1_r;
  logic               lft1_r, rgt1_r, top1_r, flr1_r;
  logic signed [31:0] px1_r, py1_r;
  logic        [47:0] ax1_r, ay1_r;

  always_ff @(posedge clk) begin
    if (go[0]) begin
      k1_r   <= in_data;
      ry1_r  <= ry_c;
      lft1_r <= lft_c;
      rgt1_r <= rgt_c;
      top1_r <= top_c;
      flr1_r <= flr_c;
      px1_r  <= rgt_c ? wr_c[31:0] : pcx_c[31:0];
      py1_r  <= flr_c ? hr_c[31:0] : pcy_c[31:0];
      ax1_r  <= in_data.avx * in_data.body.restitution;
      ay1_r  <= in_data.avy * in_data.body.restitution;
    end
  end

  // stage 2: round the first bounce products
  kin_t               k2_r;
  logic        [30:0] ry2_r;
  logic               lft2_r, rgt2_r, top2_r, flr2_r;
  logic signed [31:0] px2_r, py2_r;
  logic        [31:0] r1x2_r, r1y2_r;
  logic        [47:0] rsx_c, rsy_c;

  assign rsx_c = ax1_r + 48'd32768;
  assign rsy_c = ay1_r + 48'd32768;

  always_ff @(posedge clk) begin
    if (go[1]) begin
      k2_r   <= k1_r;
      ry2_r  <= ry1_r;
      lft2_r <= lft1_r;
      rgt2_r <= rgt1_r;
      top2_r <= top1_r;
      flr2_r <= flr1_r;
      px2_r  <= px1_r;
      py2_r  <= py1_r;
      r1x2_r <= rsx_c[47:16];
      r1y2_r <= rsy_c[47:16];
    end
  end

  // stage 3: saturate first bounce, second bounce product for double hits
  kin_t               k3_r;
  logic        [30:0] ry3_r;
  logic               lft3_r, rgt3_r, top3_r, flr3_r;
  logic signed [31:0] px3_r, py3_r;
  logic        [30:0] spx3_r, spy3_r;
  logic signed [31:0] snx3_r, sny3_r;
  logic        [47:0] m2x3_r, m2y3_r;
  logic        [30:0] spx_c, spy_c;

  assign spx_c = r1x2_r[31] ? 31'h7FFF_FFFF : r1x2_r[30:0];
  assign spy_c = r1y2_r[31] ? 31'h7FFF_FFFF : r1y2_r[30:0];

  always_ff @(posedge clk) begin
    if (go[2]) begin
      k3_r   <= k2_r;
      ry3_r  <= ry2_r;
      lft3_r <= lft2_r;
      rgt3_r <= rgt2_r;
      top3_r <= top2_r;
      flr3_r <= flr2_r;
      px3_r  <= px2_r;
      py3_r  <= py2_r;
      spx3_r <= spx_c;
      spy3_r <= spy_c;
      snx3_r <= sat_neg(r1x2_r);
      sny3_r <= sat_neg(r1y2_r);
      m2x3_r <= spx_c * k2_r.body.restitution;
      m2y3_r <= spy_c * k2_r.body.restitution;
    end
  end

  // stage 4: round the second bounce products
  kin_t               k4_r;
  logic        [30:0] ry4_r;
  logic               lft4_r, rgt4_r, top4_r, flr4_r;
  logic signed [31:0] px4_r, py4_r;
  logic        [30:0] spx4_r, spy4_r;
  logic signed [31:0] snx4_r, sny4_r;
  logic        [31:0] r2x4_r, r2y4_r;
  logic        [47:0] r2sx_c, r2sy_c;

  assign r2sx_c = m2x3_r + 48'd32768;
  assign r2sy_c = m2y3_r + 48'd32768;

  always_ff @(posedge clk) begin
    if (go[3]) begin
      k4_r   <= k3_r;
      ry4_r  <= ry3_r;
      lft4_r <= lft3_r;
      rgt4_r <= rgt3_r;
      top4_r <= top3_r;
      flr4_r <= flr3_r;
      px4_r  <= px3_r;
      py4_r  <= py3_r;
      spx4_r <= spx3_r;
      spy4_r <= spy3_r;
      snx4_r <= snx3_r;
      sny4_r <= sny3_r;
      r2x4_r <= r2sx_c[47:16];
      r2y4_r <= r2sy_c[47:16];
    end
  end

  // stage 5: pick the bounced velocity per axis
  wall_t              w5_r;
  logic signed [31:0] vx_c, vy_c;

  always_comb begin
    unique case ({lft4_r, rgt4_r})
      2'b00:   vx_c = k4_r.vx;
      2'b10:   vx_c = $signed({1'b0, spx4_r});
      2'b01:   vx_c = snx4_r;
      default: vx_c = sat_neg(r2x4_r);
    endcase
  end

  always_comb begin
    unique case ({top4_r, flr4_r})
      2'b00:   vy_c = k4_r.vy;
      2'b10:   vy_c = $signed({1'b0, spy4_r});
      2'b01:   vy_c = sny4_r;
      default: vy_c = sat_neg(r2y4_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (go[4]) begin
      w5_r.body      <= k4_r.body;
      w5_r.px        <= px4_r;
      w5_r.py        <= py4_r;
      w5_r.vx        <= vx_c;
      w5_r.vy        <= vy_c;
      w5_r.ry        <= ry4_r;
      w5_r.floor_hit <= flr4_r;
      w5_r.dv        <= k4_r.dv;
    end
  end

  assign out_data = w5_r;

endmodule

// ===== src/bib_fric.sv =====
// floor friction and result selection, two pipeline stages ending in the output register
module bib_fric (
  input  logic             clk,
  input  logic             rst_n,
  input  bib_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  bib_pkg::wall_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bib_pkg::result_t out_data
);
  import bib_pkg::*;

  localparam logic signed [34:0] FLOOR_BAND = 35'sd65536;

  // stage handshake
  logic [1:0] v_r;
  logic [2:0] go;

  assign go[2] = out_ready;
  assign go[1] = ~v_r[1] | go[2];
  assign go[0] = ~v_r[0] | go[1];

  assign in_ready  = go[0];
  assign out_valid = v_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (go[0]) v_r[0] <= in_valid;
      if (go[1]) v_r[1] <= v_r[0];
    end
  end

  // stage 1: near floor test and friction toward zero
  logic signed [34:0] pye_c, hb_c;
  logic               near_c;
  logic signed [37:0] vxe_c, dve_c, vsub_c, vadd_c;
  logic signed [31:0] vxf_c;

  assign pye_c  = 35'($signed(in_data.py)) + $signed({4'b0, in_data.ry});
  assign hb_c   = $signed({4'b0, cfg.world_height}) - FLOOR_BAND;
  assign near_c = in_data.floor_hit | (pye_c >= hb_c);
  assign vxe_c  = 38'($signed(in_data.vx));
  assign dve_c  = $signed({2'b0, in_data.dv});
  assign vsub_c = vxe_c - dve_c;
  assign vadd_c = vxe_c + dve_c;

  always_comb begin
    priority if (!near_c) begin
      vxf_c = in_data.vx;
    end else if (vxe_c > 38'sd0) begin
      vxf_c = (vsub_c < 38'sd0) ? 32'sd0 : vsub_c[31:0];
    end else if (vxe_c < 38'sd0) begin
      vxf_c = (vadd_c > 38'sd0) ? 32'sd0 : vadd_c[31:0];
    end else begin
      vxf_c = in_data.vx;
    end
  end

  body_t              b1_r;
  logic signed [31:0] px1_r, py1_r, vx1_r, vy1_r;
  logic               near1_r;

  always_ff @(posedge clk) begin
    if (go[0]) begin
      b1_r    <= in_data.body;
      px1_r   <= in_data.px;
      py1_r   <= in_data.py;
      vx1_r   <= vxf_c;
      vy1_r   <= in_data.vy;
      near1_r <= near_c;
    end
  end

  // stage 2: output register, dead bodies zeroed and static bodies passed through
  result_t res_r;

  always_ff @(posedge clk) begin
    if (go[1]) begin
      priority if (!b1_r.alive) begin
        res_r <= '0;
      end else if (b1_r.is_static) begin
        res_r.new_pos_x <= b1_r.pos_x;
        res_r.new_pos_y <= b1_r.pos_y;
        res_r.new_vel_x <= b1_r.vel_x;
        res_r.new_vel_y <= b1_r.vel_y;
        res_r.keep      <= 1'b1;
        res_r.on_floor  <= 1'b0;
      end else begin
        res_r.new_pos_x <= px1_r;
        res_r.new_pos_y <= py1_r;
        res_r.new_vel_x <= vx1_r;
        res_r.new_vel_y <= vy1_r;
        res_r.keep      <= 1'b1;
        res_r.on_floor  <= near1_r;
      end
    end
  end

  assign out_data = res_r;

endmodule

// ===== src/body_integrate_and_wall_bounce.sv =====
// top level: one body per beat through integration, wall bounce and floor friction
// pipeline: 5 integrate, 5 wall and 2 friction stages between input beat and result beat
// throughput: one body per cycle while out_tready is high, each stage holds one multiplier level or a short add chain
// stalls: each stage loads when empty or when the next stage loads, so bubbles close up
// reset: rst_n low clears all stage valid bits and loads the register reset values
module body_integrate_and_wall_bounce (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: pos_x, pos_y, vel_x, vel_y, extent_x, extent_y, restitution,
  //           friction_coef, zero pad
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bib_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: is_circle, is_static, alive
  input  logic [bib_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: new_pos_x, new_pos_y, new_vel_x, new_vel_y
  output logic [bib_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: keep, on_floor
  output logic [bib_pkg::OUT_TUSER_W-1:0] out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bib_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bib_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bib_pkg::*;

  cfg_t    cfg;
  body_t   in_body;
  kin_t    kin;
  wall_t   wal;
  result_t res;
  logic    kin_valid, kin_ready, wal_valid, wal_ready;

  // unpack the input beat
  assign in_body.pos_x         = in_tdata[31:0];
  assign in_body.pos_y         = in_tdata[63:32];
  assign in_body.vel_x         = in_tdata[95:64];
  assign in_body.vel_y         = in_tdata[127:96];
  assign in_body.extent_x      = in_tdata[158:128];
  assign in_body.extent_y      = in_tdata[189:159];
  assign in_body.restitution   = in_tdata[206:190];
  assign in_body.friction_coef = in_tdata[225:207];
  assign in_body.is_circle     = in_tuser[0];
  assign in_body.is_static     = in_tuser[1];
  assign in_body.alive         = in_tuser[2];

  bib_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bib_integ u_integ (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_body),
    .out_valid (kin_valid),
    .out_ready (kin_ready),
    .out_data  (kin)
  );

  bib_walls u_walls (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (kin_valid),
    .in_ready  (kin_ready),
    .in_data   (kin),
    .out_valid (wal_valid),
    .out_ready (wal_ready),
    .out_data  (wal)
  );

  bib_fric u_fric (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (wal_valid),
    .in_ready  (wal_ready),
    .in_data   (wal),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  // pack the result beat
  assign out_tdata = {res.new_vel_y, res.new_vel_x, res.new_pos_y, res.new_pos_x};
  assign out_tuser = {res.on_floor, res.keep};

endmodule
